// ===== hdl/ssp_pkg.sv =====
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  // vertex counts and pass counts fit in the width of the vertex_count register
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST  = 7'd64;
  localparam logic [5:0]       SOURCE_VERTEX_RST = 6'd0;

  typedef struct packed {
    logic [5:0]         from_vertex;
    logic [5:0]         to_vertex;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } in_t;

  typedef struct packed {
    logic [5:0]         vertex;
    logic signed [31:0] path_cost;
    logic               reachable;
    logic               negative_cycle;
    logic               edges_dropped;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [5:0]         from_vertex;
    logic [5:0]         to_vertex;
    logic signed [15:0] edge_weight;
  } edge_t;

  typedef struct packed {
    logic store;
    logic init;
    logic edge_rd;
    logic dist_rd;
    logic relax_f;
    logic relax_r;
    logic check;
    logic next_edge;
    logic out_rd;
    logic out_load;
    logic cyc_load;
    logic clear_run;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_last;
    logic edge_skip;
    logic edge_last;
    logic pass_last;
    logic no_pass;
    logic hit_f;
    logic hit_r;
    logic vert_last;
    logic out_free;
  } ctl_sts_t;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [15:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

endpackage

// ===== hdl/ssp_ctrl.sv =====
`timescale 1ns / 1ps
module ssp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssp_pkg::ctl_sts_t sts,
  output ssp_pkg::ctl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_INIT     = 9'b000000010,
    S_EDGE_RD  = 9'b000000100,
    S_DIST_RD  = 9'b000001000,
    S_RELAX_F  = 9'b000010000,
    S_RELAX_R  = 9'b000100000,
    S_EMIT_RD  = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_EMIT_CYC = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   check_r, check_nxt;

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    check_nxt = check_r;
    cmd       = '0;
    cmd.check = check_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (sts.in_last) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        check_nxt = sts.no_pass;
        state_nxt = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        cmd.edge_rd = 1'b1;
        state_nxt   = S_DIST_RD;
      end
      S_DIST_RD: begin
        if (sts.edge_skip) begin
          cmd.next_edge = 1'b1;
          state_nxt     = S_EDGE_RD;
          if (sts.edge_last) begin
            if (check_r) state_nxt = S_EMIT_RD;
            else if (sts.pass_last) check_nxt = 1'b1;
          end
        end else begin
          cmd.dist_rd = 1'b1;
          state_nxt   = S_RELAX_F;
        end
      end
      S_RELAX_F: begin
        cmd.relax_f = 1'b1;
        if (check_r && sts.hit_f) state_nxt = S_EMIT_CYC;
        else state_nxt = S_RELAX_R;
      end
      S_RELAX_R: begin
        cmd.relax_r = 1'b1;
        if (check_r && sts.hit_r) begin
          state_nxt = S_EMIT_CYC;
        end else begin
          cmd.next_edge = 1'b1;
          state_nxt     = S_EDGE_RD;
          if (sts.edge_last) begin
            if (check_r) state_nxt = S_EMIT_RD;
            else if (sts.pass_last) check_nxt = 1'b1;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.vert_last) begin
            cmd.clear_run = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_CYC: begin
        if (sts.out_free) begin
          cmd.cyc_load  = 1'b1;
          cmd.clear_run = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      check_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      check_r <= check_nxt;
    end
  end

endmodule

// ===== hdl/ssp_datapath.sv =====
`timescale 1ns / 1ps
module ssp_datapath #(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssp_pkg::ctl_cmd_t              cmd,
  output ssp_pkg::ctl_sts_t              sts,
  input  ssp_pkg::in_t                   in_data,
  input  logic                           cfg_valid,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssp_pkg::CFG_W-1:0]      cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ssp_pkg::out_t                  out_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int NW = ssp_pkg::CNT_W;

  // configuration
  logic [NW-1:0] vcount_r;
  logic [5:0]    src_r;
  logic [NW-1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= ssp_pkg::VERTEX_COUNT_RST;
      src_r    <= ssp_pkg::SOURCE_VERTEX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssp_pkg::REG_VERTEX_COUNT:  vcount_r <= cfg_data[NW-1:0];
        ssp_pkg::REG_SOURCE_VERTEX: src_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcount_r == '0) n = NW'(1);
    else if (vcount_r > NW'(MAX_VERTICES)) n = NW'(MAX_VERTICES);
    else n = vcount_r;
  end

  // edge store and run counters
  ssp_pkg::edge_t edge_mem [MAX_EDGES];
  ssp_pkg::edge_t edge_q;
  logic [CW-1:0]  total_r;
  logic           ovf_r;
  logic [EW-1:0]  edge_idx_r;
  logic [NW-1:0]  pass_r;
  logic [VW-1:0]  vert_r;
  logic           full;

  assign full = (total_r == CW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      edge_mem[total_r[EW-1:0]] <= '{from_vertex: in_data.from_vertex,
                                     to_vertex:   in_data.to_vertex,
                                     edge_weight: in_data.edge_weight};
    end
    if (cmd.edge_rd) edge_q <= edge_mem[edge_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      ovf_r      <= 1'b0;
      edge_idx_r <= '0;
      pass_r     <= '0;
      vert_r     <= '0;
    end else begin
      if (cmd.store) begin
        if (full) ovf_r <= 1'b1;
        else total_r <= total_r + CW'(1);
      end
      if (cmd.clear_run) begin
        total_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (cmd.init) begin
        edge_idx_r <= '0;
        pass_r     <= '0;
        vert_r     <= '0;
      end
      if (cmd.next_edge) begin
        if (sts.edge_last) begin
          edge_idx_r <= '0;
          pass_r     <= pass_r + NW'(1);
        end else begin
          edge_idx_r <= edge_idx_r + EW'(1);
        end
      end
      if (cmd.out_load) vert_r <= vert_r + VW'(1);
    end
  end

  // distances and finite marks
  logic signed [31:0]      dist_mem [MAX_VERTICES];
  logic signed [31:0]      da_r, db_r;
  logic [MAX_VERTICES-1:0] fin_r, fin_nxt;
  logic [VW-1:0]           ia, ib, isrc;
  logic signed [31:0]      cand_f, cand_r;
  logic                    apply_f, apply_r;
  logic                    dwe;
  logic [VW-1:0]           dwa;
  logic signed [31:0]      dwd;

  assign ia   = edge_q.from_vertex[VW-1:0];
  assign ib   = edge_q.to_vertex[VW-1:0];
  assign isrc = src_r[VW-1:0];

  assign cand_f = ssp_pkg::sat_add(da_r, edge_q.edge_weight);
  assign cand_r = ssp_pkg::sat_add(db_r, edge_q.edge_weight);

  assign sts.hit_f = fin_r[ia] && (!fin_r[ib] || (db_r > cand_f));
  assign sts.hit_r = fin_r[ib] && (!fin_r[ia] || (da_r > cand_r));

  assign apply_f = cmd.relax_f && sts.hit_f && !cmd.check;
  assign apply_r = cmd.relax_r && sts.hit_r && !cmd.check;

  always_comb begin
    dwe = apply_f || apply_r;
    dwa = apply_f ? ib : ia;
    dwd = apply_f ? cand_f : cand_r;
  end

  always_comb begin
    fin_nxt = fin_r;
    if (cmd.init) begin
      fin_nxt = '0;
      if ({1'b0, src_r} < n) fin_nxt[isrc] = 1'b1;
    end else if (dwe) begin
      fin_nxt[dwa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= '0;
    else fin_r <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    // source starts at distance zero
    if (cmd.init) dist_mem[isrc] <= '0;
    else if (dwe) dist_mem[dwa] <= dwd;
    if (cmd.dist_rd) begin
      da_r <= dist_mem[ia];
      db_r <= dist_mem[ib];
    end else if (cmd.out_rd) begin
      da_r <= dist_mem[vert_r];
    end else if (apply_f) begin
      // reverse relax sees the updated far end, and the near end on a self-loop
      db_r <= cand_f;
      if (ia == ib) da_r <= cand_f;
    end
  end

  // result register
  logic          out_valid_r;
  ssp_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load || cmd.cyc_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.vertex         <= 6'(vert_r);
      out_data_r.path_cost      <= fin_r[vert_r] ? da_r : 32'sd0;
      out_data_r.reachable      <= fin_r[vert_r];
      out_data_r.negative_cycle <= 1'b0;
      out_data_r.edges_dropped  <= ovf_r;
      out_data_r.last_result    <= sts.vert_last;
    end else if (cmd.cyc_load) begin
      out_data_r.vertex         <= '0;
      out_data_r.path_cost      <= '0;
      out_data_r.reachable      <= 1'b0;
      out_data_r.negative_cycle <= 1'b1;
      out_data_r.edges_dropped  <= ovf_r;
      out_data_r.last_result    <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status
  assign sts.in_last   = in_data.last_edge;
  assign sts.edge_skip = ({1'b0, edge_q.from_vertex} >= n) || ({1'b0, edge_q.to_vertex} >= n);
  assign sts.edge_last = ((CW'(edge_idx_r) + CW'(1)) == total_r);
  assign sts.pass_last = (pass_r == (n - NW'(2)));
  assign sts.no_pass   = (n == NW'(1));
  assign sts.vert_last = ((NW'(vert_r) + NW'(1)) == n);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ===== hdl/single_source_shortest_paths.sv =====
`timescale 1ns / 1ps
// edges load one word per cycle; the word marked last starts the run
// run: an init step, then n-1 relax passes and one check pass over the stored edges;
//   the check pass stops at the first edge that still relaxes; an in-range edge takes an
//   edge read, a distance read and two relaxes, an out-of-range edge the edge read and range check
// results: per vertex a distance read then an emit, held when stalled; no new edge is taken during a run
// reset: synchronous active low; clears control, counters, finite marks and config; stores are not cleared
module single_source_shortest_paths #(
  parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssp_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssp_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssp_pkg::CFG_W-1:0]     cfg_data
);

  ssp_pkg::ctl_cmd_t cmd;
  ssp_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssp_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/ssp_checker.sv =====
`timescale 1ns / 1ps
module ssp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input ssp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input ssp_pkg::out_t out_data
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // the last edge closes the graph for the run
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_edge |=> !in_ready)
    else $error("edge taken right after last edge");

  // negative cycle report is a single, empty, final word
  a_cycle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.negative_cycle |->
      out_data.last_result && !out_data.reachable && out_data.path_cost == 32'sd0 &&
      out_data.vertex == 6'd0)
    else $error("bad negative cycle word");

  // unreachable vertex reports zero cost
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reachable |-> out_data.path_cost == 32'sd0)
    else $error("unreachable vertex with nonzero cost");

endmodule

bind single_source_shortest_paths ssp_checker u_ssp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
